// ===== rtl/cat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cat_pkg
// Shared types and constants for the compacting array table: request and
// result items, operation and status codes, and the controller interface.
// ----------------------------------------------------------------------------
package cat_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_GET    = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_DELETE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    POS_ZERO  = 2'd0,
    POS_COUNT = 2'd1,
    POS_INDEX = 2'd2,
    POS_MATCH = 2'd3
  } pos_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_GET,
    S_SEARCH,
    S_SHIFT,
    S_RESULT
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
    logic [IDX_W-1:0]   index;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   position;
    logic signed [31:0] read_value;
    logic [CNT_W-1:0]   fill_count;
  } out_item_t;

  typedef struct packed {
    logic     latch;
    logic     append_do;
    logic     get_rd;
    logic     search_step;
    logic     shift_init;
    logic     shift_step;
    logic     shift_end;
    logic     set_res;
    status_t  res_status;
    pos_sel_t res_pos_sel;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  out_of_range;
    logic  hit;
    logic  scan_end;
    logic  shift_done;
    logic  out_free;
  } sts_t;

endpackage

// ===== rtl/compacting_array_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_array_table_unit
// Bounded table of signed 32-bit words with append, get, find and delete;
// delete removes the lowest match and moves later entries down by one.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_ready  | in_item  (kind, value, index)
//   out     | out_valid / out_ready| out_item (status, position,
//           |                      |           read_value, fill_count)
//
// Append and get pass from dispatch through their own state to the result.
// Find and delete walk the held entries through the single memory read port,
// one entry per cycle; delete then moves each later entry down one slot.
// One item is in work at a time; the next is taken only back in idle.
// Reset empties the table; the entry memory itself is not cleared.
// A result waits in the output register while the next item is accepted;
// the controller holds a finished result until that register is free.
// ----------------------------------------------------------------------------
module compacting_array_table_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cat_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output cat_pkg::out_item_t  out_item
);
  import cat_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cat_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/cat_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cat_datapath
// Entry memory, fill count, scan and shift pointers, result register and
// output register of the compacting array table.
// ----------------------------------------------------------------------------
module cat_datapath (
  input  logic                clk,
  input  logic                rst,
  input  cat_pkg::in_item_t   in_item,
  input  cat_pkg::cmd_t       cmd,
  output cat_pkg::sts_t       sts,
  output logic                out_valid,
  input  logic                out_ready,
  output cat_pkg::out_item_t  out_item
);
  import cat_pkg::*;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;
  logic               mem_we;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_waddr;
  logic [IDX_W-1:0]   mem_raddr;
  logic signed [31:0] mem_wdata;

  in_item_t           req;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   ptr;
  logic               pend;
  logic [IDX_W-1:0]   cmp_idx;
  logic [IDX_W-1:0]   wr_idx;
  status_t            res_status;
  logic [IDX_W-1:0]   res_pos;

  logic               full;
  logic               ptr_lt;
  logic               out_free;

  assign full     = (count == CNT_W'(DEPTH));
  assign ptr_lt   = (ptr < count);
  assign out_free = !out_valid || out_ready;

  assign sts.kind         = req.kind;
  assign sts.full         = full;
  assign sts.out_of_range = ({1'b0, req.index} >= count);
  assign sts.hit          = pend && (rd_data == req.value);
  assign sts.scan_end     = !ptr_lt;
  assign sts.shift_done   = !ptr_lt && !pend;
  assign sts.out_free     = out_free;

  // During compaction the word read in the previous cycle is written one slot
  // lower, so a read and a write can share a cycle.
  assign mem_we    = (cmd.append_do && !full) || (cmd.shift_step && pend);
  assign mem_waddr = cmd.append_do ? count[IDX_W-1:0] : wr_idx;
  assign mem_wdata = cmd.append_do ? req.value : rd_data;
  assign mem_re    = cmd.get_rd || ((cmd.search_step || cmd.shift_step) && ptr_lt);
  assign mem_raddr = cmd.get_rd ? req.index : ptr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= in_item;
    end
    if (cmd.search_step && ptr_lt) begin
      cmp_idx <= ptr[IDX_W-1:0];
    end
    if (cmd.shift_init) begin
      wr_idx <= cmp_idx;
    end else if (cmd.shift_step && pend) begin
      wr_idx <= wr_idx + IDX_W'(1);
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      case (cmd.res_pos_sel)
        POS_COUNT: res_pos <= count[IDX_W-1:0];
        POS_INDEX: res_pos <= req.index;
        POS_MATCH: res_pos <= cmp_idx;
        default:   res_pos <= '0;
      endcase
    end
    if (cmd.load_out) begin
      out_item.status     <= res_status;
      out_item.position   <= res_pos;
      out_item.read_value <= (req.kind == KIND_GET && res_status == ST_OK) ? rd_data : '0;
      out_item.fill_count <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ptr       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.append_do && !full) begin
        count <= count + CNT_W'(1);
      end else if (cmd.shift_end) begin
        count <= count - CNT_W'(1);
      end

      if (cmd.latch) begin
        ptr  <= '0;
        pend <= 1'b0;
      end else if (cmd.shift_init) begin
        ptr  <= {1'b0, cmp_idx} + CNT_W'(1);
        pend <= 1'b0;
      end else if (cmd.search_step || cmd.shift_step) begin
        if (ptr_lt) begin
          ptr  <= ptr + CNT_W'(1);
          pend <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end

      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count above capacity");

  a_shift_below_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift_step && pend) |-> ({1'b0, wr_idx} < count))
    else $error("compaction writes a slot outside the held entries");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("result loaded over an item not yet taken");

  a_full_append_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd.append_do && full) |=> (count == CNT_W'(DEPTH)))
    else $error("append to a full table changed the count");

endmodule

// ===== rtl/cat_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cat_ctrl
// Controller state machine: takes a request, steps the datapath through the
// append, read, scan and compaction sequences, then hands over the result.
// ----------------------------------------------------------------------------
module cat_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cat_pkg::sts_t  sts,
  output cat_pkg::cmd_t  cmd
);
  import cat_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.res_status  = ST_OK;
    cmd.res_pos_sel = POS_ZERO;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_APPEND: begin
        cmd.append_do   = 1'b1;
        cmd.set_res     = 1'b1;
        cmd.res_status  = sts.full ? ST_FULL : ST_OK;
        cmd.res_pos_sel = sts.full ? POS_ZERO : POS_COUNT;
        state_next      = S_RESULT;
      end
      S_GET: begin
        cmd.set_res = 1'b1;
        if (sts.out_of_range) begin
          cmd.res_status = ST_RANGE;
        end else begin
          cmd.get_rd      = 1'b1;
          cmd.res_pos_sel = POS_INDEX;
        end
        state_next = S_RESULT;
      end
      S_SEARCH: begin
        // The first cycle after a request is taken dispatches on its kind;
        // the scan itself only proceeds for find and delete.
        if (sts.kind == KIND_APPEND) begin
          state_next = S_APPEND;
        end else if (sts.kind == KIND_GET) begin
          state_next = S_GET;
        end else if (sts.hit) begin
          cmd.set_res     = 1'b1;
          cmd.res_pos_sel = POS_MATCH;
          if (sts.kind == KIND_DELETE) begin
            cmd.shift_init = 1'b1;
            state_next     = S_SHIFT;
          end else begin
            state_next = S_RESULT;
          end
        end else if (sts.scan_end) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          state_next     = S_RESULT;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.shift_done) begin
          cmd.shift_end = 1'b1;
          state_next    = S_RESULT;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> (state == S_SEARCH))
    else $error("request taken without entering dispatch");

  a_load_then_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (state == S_IDLE))
    else $error("controller did not return to idle after a result");

  a_shift_only_delete: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (sts.kind == KIND_DELETE))
    else $error("compaction running for a request other than delete");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for compacting_array_table_unit. A short scripted
// sequence covers the empty and full table, the word extremes, duplicates
// and deletion at either end of the table. A long random sequence follows,
// swinging the fill level between empty and full. Every result item is
// compared with its scripted result or with one predicted from the bench's
// shadow copy of the table, while both sides of the handshake idle in turn.
// ----------------------------------------------------------------------------
module testbench;
  import cat_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int PHASE_ITEMS = 270;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 48;

  typedef struct packed {
    in_item_t   req;
    logic [4:0] reps;
    logic       known;
    out_item_t  want;
  } script_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // Shadow of the table contents and fill level.
  logic signed [31:0] held_words [DEPTH];
  int                 held_count = 0;

  out_item_t   expected_results [$];
  script_row_t script_q [$];
  int          mismatches = 0;
  int          cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;

  compacting_array_table_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // Applies one request to the shadow table and returns its result item.
  function automatic out_item_t apply_request(in_item_t req);
    out_item_t res;
    int        slot;
    res = '0;
    res.status = ST_OK;
    slot = -1;
    case (req.kind)
      KIND_APPEND: begin
        if (held_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          held_words[held_count] = req.value;
          res.position = IDX_W'(held_count);
          held_count++;
        end
      end
      KIND_GET: begin
        if (int'(req.index) >= held_count) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = held_words[req.index];
          res.position = req.index;
        end
      end
      default: begin
        for (int i = 0; i < held_count; i++) begin
          if (slot < 0 && held_words[i] == req.value) slot = i;
        end
        if (slot < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.position = IDX_W'(slot);
          if (req.kind == KIND_DELETE) begin
            // Later entries close the gap; the vacated top slot keeps its word.
            for (int i = slot; i + 1 < held_count; i++) held_words[i] = held_words[i + 1];
            held_count--;
          end
        end
      end
    endcase
    res.fill_count = CNT_W'(held_count);
    return res;
  endfunction

  function automatic void add_step(kind_t k, logic signed [31:0] v,
                                   logic [IDX_W-1:0] ix, int reps);
    script_row_t row;
    row = '0;
    row.req.kind = k;
    row.req.value = v;
    row.req.index = ix;
    row.reps = 5'(reps);
    script_q.push_back(row);
  endfunction

  function automatic void add_known(kind_t k, logic signed [31:0] v, logic [IDX_W-1:0] ix,
                                    status_t st, logic [IDX_W-1:0] pos,
                                    logic signed [31:0] rv, logic [CNT_W-1:0] fc);
    script_row_t row;
    row.req.kind = k;
    row.req.value = v;
    row.req.index = ix;
    row.reps = 5'd1;
    row.known = 1'b1;
    row.want.status = st;
    row.want.position = pos;
    row.want.read_value = rv;
    row.want.fill_count = fc;
    script_q.push_back(row);
  endfunction

  // Random request, biased to grow or to drain the table, mostly aimed at
  // entries that are actually held so that searches hit and deletes compact.
  function automatic in_item_t pick_request(bit grow);
    in_item_t r;
    int       roll;
    int       app_w;
    app_w = grow ? 45 : 12;
    roll = $urandom_range(99);
    r.index = IDX_W'($urandom_range(15));
    case ($urandom_range(9))
      0, 1, 2, 3: r.value = int'($urandom_range(6)) - 3;
      4:          r.value = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default:    r.value = $urandom;
    endcase
    if (roll < app_w) begin
      r.kind = KIND_APPEND;
    end else if (roll < app_w + 20) begin
      r.kind = KIND_GET;
    end else if (roll < app_w + 40) begin
      r.kind = KIND_FIND;
    end else begin
      r.kind = KIND_DELETE;
    end
    if (held_count > 0 && $urandom_range(9) < 7) begin
      if (r.kind == KIND_GET) begin
        r.index = IDX_W'($urandom_range(held_count - 1));
      end else if (r.kind != KIND_APPEND) begin
        r.value = held_words[$urandom_range(held_count - 1)];
      end
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer(in_item_t req, logic known, out_item_t want);
    out_item_t pred;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (!in_ready);
    pred = apply_request(req);
    expected_results.push_back(known ? want : pred);
    @(negedge clk);
  endtask

  task automatic log_mismatch(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected st=%0d pos=%0d rd=%0d fill=%0d, got st=%0d pos=%0d rd=%0d fill=%0d",
               what, want.status, want.position, want.read_value, want.fill_count,
               got.status, got.position, got.read_value, got.fill_count);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        log_mismatch("unexpected result", '0, out_item);
      end else begin
        want = expected_results.pop_front();
        if (out_item.status !== want.status || out_item.position !== want.position ||
            out_item.read_value !== want.read_value ||
            out_item.fill_count !== want.fill_count) begin
          log_mismatch("result mismatch", want, out_item);
        end
      end
    end
  end

  initial begin
    in_item_t    req;
    script_row_t row;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_known(KIND_GET,    32'sd0,        4'd0,  ST_RANGE,     4'd0, 32'sd0,        5'd0);
    add_known(KIND_DELETE, 32'sd5,        4'd0,  ST_NOT_FOUND, 4'd0, 32'sd0,        5'd0);
    add_known(KIND_APPEND, 32'h8000_0000, 4'd0,  ST_OK,        4'd0, 32'sd0,        5'd1);
    add_known(KIND_APPEND, 32'h7fff_ffff, 4'd15, ST_OK,        4'd1, 32'sd0,        5'd2);
    add_known(KIND_APPEND, -32'sd1,       4'd0,  ST_OK,        4'd2, 32'sd0,        5'd3);
    add_known(KIND_APPEND, 32'h7fff_ffff, 4'd0,  ST_OK,        4'd3, 32'sd0,        5'd4);
    add_known(KIND_GET,    32'sd0,        4'd0,  ST_OK,        4'd0, 32'h8000_0000, 5'd4);
    add_known(KIND_GET,    32'sd0,        4'd4,  ST_RANGE,     4'd0, 32'sd0,        5'd4);
    // Duplicate word: the lowest slot answers.
    add_known(KIND_FIND,   32'h7fff_ffff, 4'd0,  ST_OK,        4'd1, 32'sd0,        5'd4);
    add_known(KIND_DELETE, 32'h7fff_ffff, 4'd0,  ST_OK,        4'd1, 32'sd0,        5'd3);
    add_step(KIND_FIND,    32'h7fff_ffff, 4'd0, 1);
    add_known(KIND_FIND,   32'sd0,        4'd0,  ST_NOT_FOUND, 4'd0, 32'sd0,        5'd3);
    add_known(KIND_DELETE, 32'h8000_0000, 4'd0,  ST_OK,        4'd0, 32'sd0,        5'd2);
    add_known(KIND_DELETE, 32'h7fff_ffff, 4'd0,  ST_OK,        4'd1, 32'sd0,        5'd1);
    add_step(KIND_GET,     32'sd0,        4'd0, 1);
    add_step(KIND_APPEND,  32'h5555_5555, 4'd0, 15);
    add_known(KIND_APPEND, 32'sd0,        4'd0,  ST_FULL,      4'd0, 32'sd0,        5'd16);
    add_step(KIND_GET,     32'sd0,        4'd15, 1);
    add_step(KIND_DELETE,  32'h5555_5563, 4'd0, 1);
    add_step(KIND_APPEND,  32'haaaa_aaaa, 4'd0, 1);
    add_step(KIND_DELETE,  -32'sd1,       4'd0, 1);
    add_step(KIND_FIND,    32'haaaa_aaaa, 4'd0, 1);
    add_step(KIND_GET,     32'sd0,        4'd14, 1);

    foreach (script_q[i]) begin
      row = script_q[i];
      for (int r = 0; r < int'(row.reps); r++) begin
        req = row.req;
        req.value = row.req.value + r;
        offer(req, row.known, row.want);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 65 : (ph == 3) ? 24 : 0;
      stall_pct <= (ph == 2) ? 65 : (ph == 3) ? 24 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // The sender keeps offering through a long receiver hold-off.
        if (ph == 0 && n == 120) hold_req <= 1'b1;
        offer(pick_request(((n / 64) % 2) == 0), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
